[src/acgp_pkg.sv]
// Package: shared widths, register indexes and types for the contrast gain block.
`timescale 1ns / 1ps
package acgp_pkg;
    localparam int PixW  = 8;
    localparam int MeanW = 16;
    localparam int VarW  = 24;
    localparam int StdW  = 15;
    localparam int ScW   = 10;
    localparam int MaxW  = 8;
    localparam int RadW  = 33;   // (var+256)<<8 fits in 33 bits
    localparam int RootW = 17;   // floor(sqrt) of a 33-bit value
    localparam int NumW  = 31;   // std*scale*64
    localparam int DenW  = 22;   // 25*root
    localparam int GainW = 19;   // num < 2^31 and den >= 6400, so quotient < 2^19
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] RegGlobalStd = 2'd0;
    localparam logic [CfgIdxW-1:0] RegScale     = 2'd1;
    localparam logic [CfgIdxW-1:0] RegMaxGain   = 2'd2;

    localparam int SqrtSteps = RootW;   // one result bit per stage
    localparam int DivSteps  = GainW;   // one quotient bit per stage
    localparam int QDepth    = 4;
    localparam int QPtrW     = 2;

    typedef struct packed {
        logic [PixW-1:0]  pixel;
        logic [MeanW-1:0] mean;
        logic [RadW-1:0]  rad;
        logic             last;
    } t_front;
endpackage

[src/adaptive_contrast_gain_pixel.sv]
// Top level: adaptive contrast enhancement for one grey pixel per beat.
`timescale 1ns / 1ps
// Accepts one beat per clock while the input is not stalled and returns one
// enhanced pixel per beat, in order. A beat passes through 1 input register,
// the queue, 17 square-root stages, 1 divisor stage, 19 divide stages,
// gain/difference, blend and the output register. A waiting result stalls
// the whole back pipeline; the 4-entry queue and the input register then
// absorb beats before the input stalls. Registers: 0 global_std (Q7.8),
// 1 scale_percent, 2 max_gain; write only while idle.
module adaptive_contrast_gain_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_pixel,
    input  logic [15:0] i_local_mean,
    input  logic [23:0] i_local_variance,
    input  logic        i_last_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_pixel,
    output logic        o_out_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import acgp_pkg::*;
    logic [StdW-1:0] r_std;
    logic [ScW-1:0]  r_scale;
    logic [MaxW-1:0] r_max;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_std   <= '0;
            r_scale <= ScW'(100);
            r_max   <= MaxW'(3);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegGlobalStd: r_std   <= i_cfg_data[StdW-1:0];
                RegScale:     r_scale <= i_cfg_data[ScW-1:0];
                RegMaxGain:   r_max   <= i_cfg_data[MaxW-1:0];
                default: ;
            endcase
        end
    end

    logic   f_v, f_s, q_v, q_s;
    t_front f_item, q_item;

    acgp_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_pixel, .i_local_mean, .i_local_variance, .i_last_pixel,
        .o_valid(f_v), .i_stall(f_s), .o_item(f_item)
    );
    acgp_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_stall(f_s), .i_item(f_item),
        .o_valid(q_v), .i_stall(q_s), .o_item(q_item)
    );
    acgp_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_v), .o_stall(q_s), .i_item(q_item),
        .i_global_std(r_std), .i_scale_percent(r_scale), .i_max_gain(r_max),
        .o_valid, .i_stall, .o_out_pixel, .o_out_last
    );
endmodule

[src/acgp_front.sv]
// Front end: accepts input beats and forms the square-root radicand.
`timescale 1ns / 1ps
module acgp_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [acgp_pkg::PixW-1:0]  i_pixel,
    input  logic [acgp_pkg::MeanW-1:0] i_local_mean,
    input  logic [acgp_pkg::VarW-1:0]  i_local_variance,
    input  logic                      i_last_pixel,
    output logic                      o_valid,
    input  logic                      i_stall,
    output acgp_pkg::t_front          o_item
);
    import acgp_pkg::*;
    logic   r_valid;
    t_front r_item;

    assign o_stall = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_item.pixel <= i_pixel;
            r_item.mean  <= i_local_mean;
            r_item.rad   <= {({1'b0, i_local_variance} + 25'd256), 8'd0};
            r_item.last  <= i_last_pixel;
        end
    end
endmodule

[src/acgp_queue.sv]
// Small FIFO decoupling the front end from the back-end pipeline.
`timescale 1ns / 1ps
module acgp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  acgp_pkg::t_front i_item,
    output logic            o_valid,
    input  logic            i_stall,
    output acgp_pkg::t_front o_item
);
    import acgp_pkg::*;
    t_front           r_mem [QDepth];
    logic [QPtrW-1:0] r_wp, r_rp;
    logic [QPtrW:0]   r_cnt;
    logic             push, pop;

    assign o_valid = (r_cnt != '0);
    assign o_stall = (r_cnt == (QPtrW+1)'(QDepth));
    assign push    = i_valid & ~o_stall;
    assign pop     = o_valid & ~i_stall;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
    end
endmodule

[src/acgp_back.sv]
// Back end: pipelined square root, restoring divide, cap, blend and clamp.
`timescale 1ns / 1ps
module acgp_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  acgp_pkg::t_front          i_item,
    input  logic [acgp_pkg::StdW-1:0] i_global_std,
    input  logic [acgp_pkg::ScW-1:0]  i_scale_percent,
    input  logic [acgp_pkg::MaxW-1:0] i_max_gain,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [acgp_pkg::PixW-1:0] o_out_pixel,
    output logic                      o_out_last
);
    import acgp_pkg::*;
    localparam int SxW  = 2 * SqrtSteps;   // radicand padded to whole bit pairs
    localparam int RemW = RootW + 2;
    localparam int PrdW = StdW + ScW;
    localparam int LR = SqrtSteps;         // root ready
    localparam int LD = LR + 1;            // divisor and first remainder ready
    localparam int LQ = LD + DivSteps;     // quotient ready
    localparam int LG = LQ + 1;            // capped gain and difference ready
    localparam int LT = LG + 1;            // blended value ready
    localparam int NS = LT + 1;

    // whole pipeline advances together; holds when the output is stalled
    logic adv;

    logic [NS-1:0]    r_v;
    logic [PixW-1:0]  r_pix  [LQ+1];
    logic [MeanW-1:0] r_mean [LG+1];
    logic             r_last [NS];
    logic [NumW-1:0]  r_num  [LQ];

    // square root stages: radicand, remainder, root
    logic [SxW-1:0]   r_sx   [SqrtSteps];
    logic [RemW-1:0]  r_srem [SqrtSteps];
    logic [RootW-1:0] r_sq   [SqrtSteps+1];
    // divide stages
    logic [DenW-1:0]  r_den  [DivSteps];
    logic [DenW-1:0]  r_drem [DivSteps];
    logic [GainW-1:0] r_quo  [DivSteps+1];

    logic [GainW-1:0]        cap;
    logic [GainW-1:0]        r_gain;
    logic signed [MeanW+1:0] r_diff;
    logic signed [42:0]      r_t;
    logic [PixW-1:0]         pix_c;
    logic                    r_ov;
    logic [PixW-1:0]         r_op;
    logic                    r_ol;

    // one digit of the square root: returns {remainder, root}
    function automatic logic [RemW+RootW-1:0] sqrt_step(logic [RemW-1:0] rem,
                                                        logic [RootW-1:0] root,
                                                        logic [1:0] pair);
        logic [RemW-1:0] rem2;
        logic [RemW-1:0] trial;
        rem2  = {rem[RemW-3:0], pair};
        trial = {root, 2'b01};
        if (rem2 >= trial) begin
            return {rem2 - trial, root[RootW-2:0], 1'b1};
        end else begin
            return {rem2, root[RootW-2:0], 1'b0};
        end
    endfunction

    // one restoring divide step: returns {remainder, quotient}
    function automatic logic [DenW+GainW-1:0] div_step(logic [DenW-1:0] rem,
                                                       logic [DenW-1:0] den,
                                                       logic [GainW-1:0] quo,
                                                       logic nbit);
        logic [DenW:0] part;
        part = {rem, nbit};
        if (part >= {1'b0, den}) begin
            return {DenW'(part - {1'b0, den}), quo[GainW-2:0], 1'b1};
        end else begin
            return {DenW'(part), quo[GainW-2:0], 1'b0};
        end
    endfunction

    assign adv     = ~(o_valid & i_stall);
    assign o_stall = ~adv;
    assign cap     = GainW'({i_max_gain, 8'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[NS-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // side data carried along
            r_pix[0]  <= i_item.pixel;
            r_mean[0] <= i_item.mean;
            r_last[0] <= i_item.last;
            for (int k = 1; k <= LQ; k++) r_pix[k] <= r_pix[k-1];
            for (int k = 1; k <= LG; k++) r_mean[k] <= r_mean[k-1];
            for (int k = 1; k < NS; k++) r_last[k] <= r_last[k-1];

            // numerator std*scale*64, carried until the divider has used it
            r_num[0] <= {PrdW'(i_global_std) * PrdW'(i_scale_percent), 6'd0};
            for (int k = 1; k < LQ; k++) r_num[k] <= r_num[k-1];

            // digit-by-digit square root, two radicand bits per stage
            r_sx[0]   <= {1'b0, i_item.rad};
            r_srem[0] <= '0;
            r_sq[0]   <= '0;
            for (int k = 0; k < SqrtSteps - 1; k++) begin
                r_sx[k+1] <= {r_sx[k][SxW-3:0], 2'b00};
                {r_srem[k+1], r_sq[k+1]} <= sqrt_step(r_srem[k], r_sq[k],
                                                      r_sx[k][SxW-1 -: 2]);
            end
            r_sq[SqrtSteps] <= RootW'(sqrt_step(r_srem[SqrtSteps-1], r_sq[SqrtSteps-1],
                                                r_sx[SqrtSteps-1][SxW-1 -: 2]));

            // restoring divide; high numerator bits preload the remainder
            r_den[0]  <= {5'd0, r_sq[SqrtSteps]} * DenW'(25);
            r_drem[0] <= DenW'(r_num[LR][NumW-1:DivSteps]);
            r_quo[0]  <= '0;
            for (int d = 0; d < DivSteps - 1; d++) begin
                r_den[d+1] <= r_den[d];
                {r_drem[d+1], r_quo[d+1]} <= div_step(r_drem[d], r_den[d], r_quo[d],
                                                      r_num[LD+d][DivSteps-1-d]);
            end
            r_quo[DivSteps] <= GainW'(div_step(r_drem[DivSteps-1], r_den[DivSteps-1],
                                               r_quo[DivSteps-1], r_num[LQ-1][0]));

            // cap, blend
            r_gain <= (r_quo[DivSteps] > cap) ? cap : r_quo[DivSteps];
            r_diff <= $signed({2'b00, r_pix[LQ], 8'd0}) - $signed({2'b00, r_mean[LQ]});
            r_t    <= $signed({19'd0, r_mean[LG], 8'd0})
                    + $signed({1'b0, r_gain}) * r_diff;

            r_op <= pix_c;
            r_ol <= r_last[LT];
        end
    end

    always_comb begin
        if (r_t < 0) pix_c = '0;
        else if (r_t >= 43'sd16711680) pix_c = 8'd255;
        else pix_c = r_t[23:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= r_v[LT];
    end

    assign o_valid     = r_ov;
    assign o_out_pixel = r_op;
    assign o_out_last  = r_ol;
endmodule

[sim/tb.sv]
// Testbench for adaptive_contrast_gain_pixel: directed and random pixels vs an own predictor.
`timescale 1ns / 1ps
module tb;
    import acgp_pkg::*;

    // Expected output of one pixel beat
    typedef struct {
        logic [7:0] pix;
        logic       last;
    } t_enh;

    // Keeps the register copy, predicts each enhanced pixel and checks results in order
    class enh_board;
        logic [14:0] gstd;
        logic [9:0]  scl;
        logic [7:0]  gmax;
        t_enh        pending[$];
        int          errors;
        int          checked;

        function new();
            gstd = 0; scl = 10'd100; gmax = 8'd3; errors = 0; checked = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] d);
            case (idx)
                RegGlobalStd: gstd = d[14:0];
                RegScale:     scl  = d[9:0];
                RegMaxGain:   gmax = d[7:0];
                default: ;
            endcase
        endfunction

        // Bitwise integer square root, truncated
        function longint unsigned int_root(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void note_pixel(logic [7:0] p, logic [15:0] m, logic [23:0] v, logic l);
            longint unsigned rt, g, lim;
            longint          diff, t;
            t_enh            e;
            rt  = int_root((64'(v) + 256) << 8);
            g   = (64'(gstd) * 64'(scl) * 64) / (25 * rt);
            lim = 64'(gmax) * 256;
            if (g > lim) g = lim;
            diff = longint'(64'(p) * 256) - longint'(64'(m));
            t    = longint'(64'(m) * 256) + longint'(g) * diff;
            if (t < 0) e.pix = 8'd0;
            else if (t >= 255 * 65536) e.pix = 8'd255;
            else e.pix = t[23:16];
            e.last = l;
            pending.push_back(e);
        endfunction

        function void check_pixel(logic [7:0] p, logic l);
            t_enh e;
            if (pending.size() == 0) begin
                $error("unexpected result: out_pixel %0d out_last %0d", p, l);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (p !== e.pix) begin
                $error("out_pixel mismatch: expected %0d actual %0d", e.pix, p);
                errors++;
            end
            if (l !== e.last) begin
                $error("out_last mismatch: expected %0d actual %0d", e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [7:0]  i_pixel = 0;
    logic [15:0] i_local_mean = 0;
    logic [23:0] i_local_variance = 0;
    logic        i_last_pixel = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [7:0]  o_out_pixel;
    logic        o_out_last;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0;

    adaptive_contrast_gain_pixel uut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    enh_board sb = new();
    int  sent;
    int  idle_pct;      // sender gap odds in percent
    int  sink_pct;      // receiver stall odds in percent
    int  hold_cycles;   // long receiver hold-off, counted by the sink process
    int  quiet = 0;

    // Watchdog: cycles with no beat accepted anywhere
    localparam int QuietLimit = 20000;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QuietLimit) begin
            $display("watchdog: no progress for %0d cycles", QuietLimit);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: samples at the rising edge, sets stall at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_pixel(o_out_pixel, o_out_last);
    end
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom_range(99) < sink_pct);
        end
    end

    // Valid stays high into the next beat; idle gaps and drain() drop it
    task automatic send_pixel(logic [7:0] p, logic [15:0] m, logic [23:0] v, logic l);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid          <= 1;
        i_pixel          <= p;
        i_local_mean     <= m;
        i_local_variance <= v;
        i_last_pixel     <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_pixel(p, m, v, l);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, d);
        @(negedge i_clk);
        i_cfg_valid <= 0;
        @(negedge i_clk);
    endtask

    // Waits until every expected pixel is back, then past the pipeline depth
    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // Mostly mid-range values, with some extremes mixed in
    task automatic random_pixel();
        logic [15:0] m;
        logic [23:0] v;
        m = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(255 * 256));
        case ($urandom_range(3))
            0: v = 24'($urandom);
            1: v = 24'($urandom_range(4095));
            2: v = 24'($urandom_range(255));
            default: v = ($urandom_range(1)) ? 24'hFFFFFF : 24'd0;
        endcase
        send_pixel(8'($urandom), m, v, ($urandom_range(15) == 0));
    endtask

    task automatic set_regs(logic [31:0] s, logic [31:0] c, logic [31:0] g);
        write_reg(RegGlobalStd, s);
        write_reg(RegScale, c);
        write_reg(RegMaxGain, g);
    endtask

    initial begin
        sent = 0; idle_pct = 33; sink_pct = 33; hold_cycles = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: reset registers, std of zero gives the truncated mean
        send_pixel(8'd255, 16'hFFFF, 24'd0, 1'b1);
        send_pixel(8'd0, 16'h0000, 24'hFFFFFF, 1'b0);
        drain();
        // Strong gain pushing to both clamps, and a cap of zero
        set_regs(32'h7FFF, 32'd1023, 32'd255);
        send_pixel(8'd255, 16'h0100, 24'd0, 1'b0);
        send_pixel(8'd0, 16'hFF00, 24'd0, 1'b1);
        send_pixel(8'd128, 16'h8000, 24'hFFFFFF, 1'b0);
        send_pixel(8'd200, 16'h6480, 24'd100, 1'b0);
        drain();
        write_reg(RegMaxGain, 32'h0000_0100);   // upper bits dropped: cap of zero
        send_pixel(8'd255, 16'h1234, 24'd5, 1'b0);
        send_pixel(8'd0, 16'hFFFF, 24'd5, 1'b1);
        drain();
        set_regs(32'hFFFF_0100, 32'd0, 32'd3);  // zero scale
        send_pixel(8'd10, 16'h8080, 24'd1000, 1'b0);
        drain();
        write_reg(2'd3, 32'hDEAD_BEEF);         // index past the register list
        send_pixel(8'd250, 16'h0A00, 24'd1000, 1'b1);
        drain();

        // Random phases with various register settings
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: set_regs(32'h0100, 32'd100, 32'd3);
                1: set_regs(32'h7FFF, 32'd1023, 32'd255);
                2: set_regs(32'd0, 32'd0, 32'd0);
                default: set_regs($urandom, $urandom, $urandom_range(1) ? $urandom_range(8) : $urandom);
            endcase
            idle_pct = (ph == 4) ? 0 : 33;
            sink_pct = (ph == 4) ? 0 : 33;
            if (ph == 5) hold_cycles = 300;     // receiver holds off while pixels keep coming
            repeat (150) random_pixel();
            drain();
        end

        $display("Sent %0d pixels, checked %0d results over directed and random register settings,",
                 sent, sb.checked);
        $display("including clamps, zero gain, stalls and a long receiver hold-off.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
